@@ src/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	// 255 * offset / 360 for the sector offsets 120, 240 and 360 degrees
	localparam logic [7:0] HUE_OFF_GREEN = 8'd85;
	localparam logic [7:0] HUE_OFF_BLUE  = 8'd170;
	localparam logic [7:0] HUE_OFF_WRAP  = 8'd255;

	// hue fraction = floor(85 * |delta| / (2 * d)), saturation = floor(255 * d / max)
	localparam int unsigned HUE_NUM_SCALE = 85;
	localparam int unsigned SAT_NUM_SCALE = 255;

	localparam int unsigned QUO_W      = 8;
	localparam int unsigned REM_W      = 16;
	localparam int unsigned DIVISOR_W  = 9;
	localparam int unsigned BITS_STAGE = 2;
	localparam int unsigned DIV_STAGES = QUO_W / BITS_STAGE;

endpackage

@@ src/hsv_stream_if.sv @@
// ----------------------------------------------------------------------------
// hsv_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface hsv_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ src/rgb_to_hsv_pixel.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// Converts 8-bit RGB pixels to 8-bit hue, saturation and value in a
// seven-stage pipeline with two restoring-division bits per division stage.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        handshake
//  pixel    in   rgb_t {red, green, blue}       valid / ready
//  hsv      out  hsv_t {hue, saturation,        valid / ready
//                       brightness}
//
//  One pixel enters every cycle while no result waits at the output.
//  The two 8-bit quotients are resolved two bits per division stage.
//  arst_n clears the stage valid bits only; data registers are not reset.
//  The whole pipeline holds while a result waits at the output; pixel.ready
//  is high whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
	import rgbhsv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	hsv_stream_if.sink   pixel,
	hsv_stream_if.source hsv
);

	typedef struct packed {
		logic                 flat;
		logic                 neg;
		logic [7:0]           off;
		logic [7:0]           mx;
		logic [REM_W-1:0]     srem;
		logic [QUO_W-1:0]     sq;
		logic [7:0]           sdiv;
		logic [REM_W-1:0]     hrem;
		logic [QUO_W-1:0]     hq;
		logic [DIVISOR_W-1:0] hdiv;
	} div_stage_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic             qbit;
	} div_step_t;

	function automatic div_step_t div_step(input logic [REM_W-1:0] rem,
			input logic [DIVISOR_W-1:0] dvs, input int unsigned sh);
		logic [REM_W:0] shifted;
		div_step_t      res;
		shifted = (REM_W+1)'(dvs) << sh;
		if ({1'b0, rem} >= shifted) begin
			res.rem  = rem - shifted[REM_W-1:0];
			res.qbit = 1'b1;
		end else begin
			res.rem  = rem;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

	logic adv;

	// stage 1: max, min, sector
	logic       v_s1;
	logic       flat_s1, neg_s1;
	logic [7:0] off_s1, mx_s1, d_s1, mag_s1;

	// stage 2: numerators
	logic                 v_s2;
	logic                 flat_s2, neg_s2;
	logic [7:0]           off_s2, mx_s2;
	logic [REM_W-1:0]     sn_s2, hn_s2;
	logic [DIVISOR_W-1:0] hd_s2;

	// stages 3..6: division
	logic       dv_s [DIV_STAGES];
	div_stage_t dp_s [DIV_STAGES];

	// stage 7: output register
	logic v_s7;
	hsv_t res_s7;

	assign adv         = !v_s7 || hsv.ready;
	assign pixel.ready = adv;
	assign hsv.valid   = v_s7;
	assign hsv.data    = res_s7;

	// ---- stage 1 logic ----
	logic [7:0] r_c, g_c, b_c, mx_c, mn_c, d_c, mag_c, off_c;
	logic       neg_c;
	logic [8:0] delta_c;

	always_comb begin
		r_c  = pixel.data.red;
		g_c  = pixel.data.green;
		b_c  = pixel.data.blue;
		mx_c = (r_c > g_c) ? r_c : g_c;
		mx_c = (mx_c > b_c) ? mx_c : b_c;
		mn_c = (r_c < g_c) ? r_c : g_c;
		mn_c = (mn_c < b_c) ? mn_c : b_c;
		d_c  = mx_c - mn_c;
		// red wins ties, then green
		if (r_c == mx_c) begin
			delta_c = {1'b0, g_c} - {1'b0, b_c};
			off_c   = delta_c[8] ? HUE_OFF_WRAP : 8'd0;
		end else if (g_c == mx_c) begin
			delta_c = {1'b0, b_c} - {1'b0, r_c};
			off_c   = HUE_OFF_GREEN;
		end else begin
			delta_c = {1'b0, r_c} - {1'b0, g_c};
			off_c   = HUE_OFF_BLUE;
		end
		neg_c = delta_c[8];
		mag_c = neg_c ? 8'(-delta_c) : delta_c[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s7 <= dv_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flat_s1 <= (d_c == 8'd0);
			neg_s1  <= neg_c;
			off_s1  <= off_c;
			mx_s1   <= mx_c;
			d_s1    <= d_c;
			mag_s1  <= mag_c;

			flat_s2 <= flat_s1;
			neg_s2  <= neg_s1;
			off_s2  <= off_s1;
			mx_s2   <= mx_s1;
			sn_s2   <= REM_W'(SAT_NUM_SCALE * d_s1);
			hn_s2   <= REM_W'(HUE_NUM_SCALE * mag_s1);
			hd_s2   <= {d_s1, 1'b0};
		end
	end

	// ---- division stages ----
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_stage_t in_c, out_c;
		div_step_t  s_hi, s_lo, h_hi, h_lo;

		if (k == 0) begin : g_first
			always_comb begin
				in_c.flat = flat_s2;
				in_c.neg  = neg_s2;
				in_c.off  = off_s2;
				in_c.mx   = mx_s2;
				in_c.srem = sn_s2;
				in_c.sq   = '0;
				in_c.sdiv = mx_s2;
				in_c.hrem = hn_s2;
				in_c.hq   = '0;
				in_c.hdiv = hd_s2;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[k] <= 1'b0;
				end else if (adv) begin
					dv_s[k] <= v_s2;
				end
			end
		end else begin : g_next
			assign in_c = dp_s[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[k] <= 1'b0;
				end else if (adv) begin
					dv_s[k] <= dv_s[k-1];
				end
			end
		end

		always_comb begin
			s_hi = div_step(in_c.srem, {1'b0, in_c.sdiv}, QUO_W - 1 - BITS_STAGE*k);
			s_lo = div_step(s_hi.rem, {1'b0, in_c.sdiv}, QUO_W - 2 - BITS_STAGE*k);
			h_hi = div_step(in_c.hrem, in_c.hdiv, QUO_W - 1 - BITS_STAGE*k);
			h_lo = div_step(h_hi.rem, in_c.hdiv, QUO_W - 2 - BITS_STAGE*k);
			out_c      = in_c;
			out_c.srem = s_lo.rem;
			out_c.sq   = {in_c.sq[QUO_W-3:0], s_hi.qbit, s_lo.qbit};
			out_c.hrem = h_lo.rem;
			out_c.hq   = {in_c.hq[QUO_W-3:0], h_hi.qbit, h_lo.qbit};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dp_s[k] <= out_c;
			end
		end
	end

	// ---- output stage ----
	div_stage_t last_c;
	hsv_t       res_c;

	always_comb begin
		last_c = dp_s[DIV_STAGES-1];
		res_c.brightness = last_c.mx;
		if (last_c.flat) begin
			res_c.hue        = 8'd0;
			res_c.saturation = 8'd0;
		end else begin
			res_c.saturation = last_c.sq;
			// negative delta takes the ceiling of the fraction
			if (last_c.neg) begin
				res_c.hue = last_c.off - last_c.hq - {7'd0, |last_c.hrem};
			end else begin
				res_c.hue = last_c.off + last_c.hq;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s7 <= res_c;
		end
	end

endmodule

@@ tb/sv/rgb_to_hsv_pixel_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// Self-checking bench for the RGB to HSV pixel converter. Pixels go in over
// the input stream with random gaps and the output is stalled at random. Each
// result is compared field by field against an integer HSV computation done
// in the bench.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb
	import rgbhsv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	hsv_stream_if #(.T(rgb_t)) pixel_if ();
	hsv_stream_if #(.T(hsv_t)) hsv_if ();

	rgb_to_hsv_pixel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_if.sink),
		.hsv    (hsv_if.source)
	);

	hsv_t hsv_expected[$];
	int   pixels_sent;
	int   results_checked;
	int   mismatch_count;
	bit   gaps_on;
	int   hold_request;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exact integer HSV, hue sector chosen red first, then green, then blue
	function automatic hsv_t compute_hsv(rgb_t px);
		int unsigned r, g, b, mx, mn, d, num;
		hsv_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		res = '0;
		res.brightness = mx[7:0];
		if (mx == 0 || mx == mn)
			return res;
		d = mx - mn;
		res.saturation = 8'((255 * d) / mx);
		if (r == mx) begin
			num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
		end else if (g == mx) begin
			num = (b >= r) ? 120 * d + 60 * (b - r) : 120 * d - 60 * (r - b);
		end else begin
			num = (r >= g) ? 240 * d + 60 * (r - g) : 240 * d - 60 * (g - r);
		end
		res.hue = 8'((255 * num) / (360 * d));
		return res;
	endfunction

	// biased toward grey, ties and channel extremes
	function automatic rgb_t random_pixel();
		rgb_t px;
		logic [7:0] v;
		px = rgb_t'($urandom);
		v = 8'($urandom);
		case ($urandom_range(0, 9))
			0: px = '{v, v, v};
			1: px.green = px.red;
			2: px.blue = px.green;
			3: px.blue = px.red;
			4: px.red = 8'hff;
			5: px = '{8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3))};
			6: px = '{v, 8'(v - $urandom_range(0, 2)), 8'(v - $urandom_range(0, 2))};
			default: ;
		endcase
		return px;
	endfunction

	task automatic send_pixel(rgb_t px);
		int gap;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			pixel_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_if.valid <= 1'b1;
		pixel_if.data  <= px;
		do @(posedge clk); while (!pixel_if.ready);
		hsv_expected.push_back(compute_hsv(px));
		pixels_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		pixel_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (hsv_expected.size() != 0) @(posedge clk);
	endtask

	// receiver: one stall draw per result beat, long hold on request
	initial begin
		int stall;
		hsv_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = gaps_on ? $urandom_range(0, 19) : 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				hsv_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			hsv_if.ready <= 1'b1;
			do @(posedge clk); while (!hsv_if.valid);
		end
	end

	always @(posedge clk) begin
		hsv_t want;
		if (arst_n && hsv_if.valid && hsv_if.ready) begin
			if (hsv_expected.size() == 0) begin
				$display("%0t: unexpected result beat %p", $realtime, hsv_if.data);
				mismatch_count++;
			end else begin
				want = hsv_expected.pop_front();
				results_checked++;
				if (hsv_if.data.hue !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $realtime,
						want.hue, hsv_if.data.hue);
					mismatch_count++;
				end
				if (hsv_if.data.saturation !== want.saturation) begin
					$display("%0t: saturation expected %0d actual %0d", $realtime,
						want.saturation, hsv_if.data.saturation);
					mismatch_count++;
				end
				if (hsv_if.data.brightness !== want.brightness) begin
					$display("%0t: brightness expected %0d actual %0d", $realtime,
						want.brightness, hsv_if.data.brightness);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_directed();
		rgb_t cases [24];
		cases = '{
			'{8'd0,   8'd0,   8'd0},    // black
			'{8'd255, 8'd255, 8'd255},  // white
			'{8'd1,   8'd1,   8'd1},
			'{8'd128, 8'd128, 8'd128},
			'{8'd255, 8'd0,   8'd0},
			'{8'd0,   8'd255, 8'd0},
			'{8'd0,   8'd0,   8'd255},
			'{8'd255, 8'd255, 8'd0},    // red/green tie
			'{8'd0,   8'd255, 8'd255},  // green/blue tie
			'{8'd255, 8'd0,   8'd255},  // red/blue tie, wraps
			'{8'd255, 8'd0,   8'd1},    // just below 360 deg
			'{8'd255, 8'd1,   8'd0},
			'{8'd1,   8'd0,   8'd0},
			'{8'd0,   8'd1,   8'd0},
			'{8'd0,   8'd0,   8'd1},
			'{8'd255, 8'd254, 8'd254},  // d = 1
			'{8'd254, 8'd255, 8'd253},
			'{8'd200, 8'd100, 8'd50},
			'{8'd50,  8'd200, 8'd100},
			'{8'd100, 8'd50,  8'd200},
			'{8'd100, 8'd200, 8'd50},
			'{8'd50,  8'd100, 8'd200},
			'{8'd170, 8'd85,  8'd255},
			'{8'h55,  8'haa,  8'h55}
		};
		gaps_on = 1'b0;
		foreach (cases[i]) send_pixel(cases[i]);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) gaps_on = ~gaps_on;
			send_pixel(random_pixel());
		end
	endtask

	// output held off while input keeps offering, so the pipeline fills
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = 300;
		for (int i = 0; i < 60; i++) send_pixel(random_pixel());
	endtask

	// sender stops until everything is back, then resumes
	task automatic test_drain_pause();
		gaps_on = 1'b1;
		for (int i = 0; i < 20; i++) send_pixel(random_pixel());
		idle_input();
		wait_drained();
		gaps_on = 1'b0;
		for (int i = 0; i < 20; i++) send_pixel(random_pixel());
	endtask

	initial begin
		pixel_if.valid = 1'b0;
		pixel_if.data  = '0;
		arst_n = 1'b0;
		gaps_on = 1'b0;
		hold_request = 0;
		pixels_sent = 0;
		results_checked = 0;
		mismatch_count = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random(250);
		test_backpressure();
		test_drain_pause();
		test_random(250);

		idle_input();
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Converted %0d pixels and checked %0d results: black, grey, ties,",
			pixels_sent, results_checked);
		$display("all hue sectors, random gaps and stalls, full output hold-off.");
		if (mismatch_count == 0 && hsv_expected.size() == 0) begin
			$display("PASS rgb_to_hsv_pixel");
		end else begin
			$display("FAIL rgb_to_hsv_pixel");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL rgb_to_hsv_pixel");
		$finish;
	end

endmodule
